>>> hw/rtl/three_marker_pose_estimator_defines.svh
`ifndef THREE_MARKER_POSE_ESTIMATOR_DEFINES_SVH
`define THREE_MARKER_POSE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/tmpe_pkg.sv
package tmpe_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_INT_BITS  = 11;
    localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_INT_BITS      = 3;

    localparam int CENTER_W     = 17;
    localparam int HEADING_W    = 16;
    localparam int FRONT_W      = 2;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int DIST_W       = SQ_W + 1;
    localparam int SUM_W        = COORD_W + 2;
    localparam int DIFF_W       = COORD_W + 3;
    localparam int CORDIC_GUARD = 8;
    localparam int XY_W         = DIFF_W + CORDIC_GUARD + 2;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [FRONT_W-1:0] FRONT_LED0 = 2'd0;
    localparam logic [FRONT_W-1:0] FRONT_LED1 = 2'd1;
    localparam logic [FRONT_W-1:0] FRONT_LED2 = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [FRONT_W-1:0]  front;
        logic                zero;
    } side_t;

    localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint PI_Q30      = 64'sd3373259426;

    function automatic longint q30_to_angle(input longint q30, input int frac_bits);
        return (q30 + (longint'(1) <<< (29 - frac_bits))) >>> (30 - frac_bits);
    endfunction

endpackage

>>> hw/rtl/tmpe_front.sv
module tmpe_front import tmpe_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int Z_W             = ANGLE_FRAC_BITS + ANGLE_INT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  coord_t                led0_x,
    input  coord_t                led0_y,
    input  coord_t                led1_x,
    input  coord_t                led1_y,
    input  coord_t                led2_x,
    input  coord_t                led2_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out,
    output side_t                 side_out
);

    localparam logic signed [Z_W-1:0] PI_HALF_Q = Z_W'(q30_to_angle(PI_HALF_Q30, ANGLE_FRAC_BITS));

    // stage A: squared differences
    logic                 a_valid_reg;
    coord_t               a_px_reg [3];
    coord_t               a_py_reg [3];
    logic [SQ_W-1:0]      a_sq_reg [6];
    logic signed [COORD_W:0]     diff [6];
    logic signed [2*COORD_W+1:0] prod [6];

    // stage B: distances and coordinate sums
    logic                 b_valid_reg;
    coord_t               b_px_reg [3];
    coord_t               b_py_reg [3];
    logic [DIST_W-1:0]    b_dist_reg [3];
    logic [SUM_W-1:0]     b_sum_x_reg;
    logic [SUM_W-1:0]     b_sum_y_reg;

    // stage C: front choice
    logic                 c_valid_reg;
    coord_t               c_px_reg [3];
    coord_t               c_py_reg [3];
    logic [SUM_W-1:0]     c_sum_x_reg;
    logic [SUM_W-1:0]     c_sum_y_reg;
    logic [FRONT_W-1:0]   c_front_reg;
    logic [FRONT_W-1:0]   c_front_next;

    // stage D: centre and heading vector
    logic                 d_valid_reg;
    logic signed [DIFF_W-1:0] d_dx_reg;
    logic signed [DIFF_W-1:0] d_dy_reg;
    side_t                d_side_reg;
    coord_t               fx;
    coord_t               fy;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    side_t                d_side_next;

    // stage E: quadrant fold
    logic                 e_valid_reg;
    logic signed [XY_W-1:0] e_x_reg;
    logic signed [XY_W-1:0] e_y_reg;
    logic signed [Z_W-1:0]  e_z_reg;
    side_t                e_side_reg;
    logic signed [XY_W-1:0] gx;
    logic signed [XY_W-1:0] gy;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;

    logic a_en, b_en, c_en, d_en, e_en;

    assign e_en     = !e_valid_reg || out_ready;
    assign d_en     = !d_valid_reg || e_en;
    assign c_en     = !c_valid_reg || d_en;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    always_comb begin
        diff[0] = $signed({1'b0, led0_x}) - $signed({1'b0, led1_x});
        diff[1] = $signed({1'b0, led0_y}) - $signed({1'b0, led1_y});
        diff[2] = $signed({1'b0, led1_x}) - $signed({1'b0, led2_x});
        diff[3] = $signed({1'b0, led1_y}) - $signed({1'b0, led2_y});
        diff[4] = $signed({1'b0, led2_x}) - $signed({1'b0, led0_x});
        diff[5] = $signed({1'b0, led2_y}) - $signed({1'b0, led0_y});
        for (int k = 0; k < 6; k++) begin
            prod[k] = diff[k] * diff[k];
        end
    end

    always_comb begin
        if (b_dist_reg[0] < b_dist_reg[1] && b_dist_reg[0] < b_dist_reg[2]) begin
            c_front_next = FRONT_LED2;
        end else if (b_dist_reg[1] < b_dist_reg[2] && b_dist_reg[1] < b_dist_reg[0]) begin
            c_front_next = FRONT_LED0;
        end else begin
            c_front_next = FRONT_LED1;
        end
    end

    always_comb begin
        case (c_front_reg)
            FRONT_LED0: begin
                fx = c_px_reg[0];
                fy = c_py_reg[0];
            end
            FRONT_LED2: begin
                fx = c_px_reg[2];
                fy = c_py_reg[2];
            end
            default: begin
                fx = c_px_reg[1];
                fy = c_py_reg[1];
            end
        endcase
        dx_next = $signed(DIFF_W'({fx, 1'b0})) + $signed(DIFF_W'(fx))
                - $signed(DIFF_W'(c_sum_x_reg));
        dy_next = $signed(DIFF_W'({fy, 1'b0})) + $signed(DIFF_W'(fy))
                - $signed(DIFF_W'(c_sum_y_reg));
        d_side_next.center_x = CENTER_W'(fx) + CENTER_W'(c_sum_x_reg);
        d_side_next.center_y = CENTER_W'(fy) + CENTER_W'(c_sum_y_reg);
        d_side_next.front    = c_front_reg;
        d_side_next.zero     = (dx_next == '0) && (dy_next == '0);
    end

    always_comb begin
        gx = $signed(XY_W'(d_dx_reg)) <<< CORDIC_GUARD;
        gy = $signed(XY_W'(d_dy_reg)) <<< CORDIC_GUARD;
        if (gx < 0) begin
            if (gy >= 0) begin
                x_next = gy;
                y_next = -gx;
                z_next = PI_HALF_Q;
            end else begin
                x_next = -gy;
                y_next = gx;
                z_next = -PI_HALF_Q;
            end
        end else begin
            x_next = gx;
            y_next = gy;
            z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= in_valid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en) begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_en) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_px_reg[0] <= led0_x;
            a_px_reg[1] <= led1_x;
            a_px_reg[2] <= led2_x;
            a_py_reg[0] <= led0_y;
            a_py_reg[1] <= led1_y;
            a_py_reg[2] <= led2_y;
            for (int k = 0; k < 6; k++) begin
                a_sq_reg[k] <= prod[k][SQ_W-1:0];
            end
        end
        if (b_en) begin
            b_px_reg <= a_px_reg;
            b_py_reg <= a_py_reg;
            for (int k = 0; k < 3; k++) begin
                b_dist_reg[k] <= {1'b0, a_sq_reg[2*k]} + {1'b0, a_sq_reg[2*k+1]};
            end
            b_sum_x_reg <= SUM_W'(a_px_reg[0]) + SUM_W'(a_px_reg[1]) + SUM_W'(a_px_reg[2]);
            b_sum_y_reg <= SUM_W'(a_py_reg[0]) + SUM_W'(a_py_reg[1]) + SUM_W'(a_py_reg[2]);
        end
        if (c_en) begin
            c_px_reg    <= b_px_reg;
            c_py_reg    <= b_py_reg;
            c_sum_x_reg <= b_sum_x_reg;
            c_sum_y_reg <= b_sum_y_reg;
            c_front_reg <= c_front_next;
        end
        if (d_en) begin
            d_dx_reg   <= dx_next;
            d_dy_reg   <= dy_next;
            d_side_reg <= d_side_next;
        end
        if (e_en) begin
            e_x_reg    <= x_next;
            e_y_reg    <= y_next;
            e_z_reg    <= z_next;
            e_side_reg <= d_side_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign x_out     = e_x_reg;
    assign y_out     = e_y_reg;
    assign z_out     = e_z_reg;
    assign side_out  = e_side_reg;

endmodule

>>> hw/rtl/tmpe_cordic_cell.sv
module tmpe_cordic_cell import tmpe_pkg::*; #(
    parameter int STAGE           = 0,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int Z_W             = ANGLE_FRAC_BITS + ANGLE_INT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  side_t                  side_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out,
    output side_t                  side_out
);

    localparam logic signed [Z_W-1:0] ATAN_STEP =
        Z_W'(q30_to_angle(ATAN_Q30[STAGE], ANGLE_FRAC_BITS));

    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    side_t                  side_reg;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic                   en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        if (y_in >= 0) begin
            x_next = x_in + (y_in >>> STAGE);
            y_next = y_in - (x_in >>> STAGE);
            z_next = z_in + ATAN_STEP;
        end else begin
            x_next = x_in - (y_in >>> STAGE);
            y_next = y_in + (x_in >>> STAGE);
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

>>> hw/rtl/three_marker_pose_estimator.sv
// Pose from three marker centroids (unsigned Q11.4). The closest pair is the back, the third
// marker the front (ties fall to LED1 as front). Outputs the centre (2*front + a + b)/4 in
// Q11.6, the heading from back to front in signed radians with ANGLE_FRAC_BITS fraction bits
// (clamped to +-pi, 0 for a zero vector), and the front marker index. Takes one beat per
// clock while not stalled by back-pressure and delivers one result beat per input beat,
// in order. The pipeline registers squared distances, distance sums, front selection,
// centre/vector and quadrant fold, then each CORDIC cell, then the output register.
// Back-pressure stalls only the stages that hold data.
`include "three_marker_pose_estimator_defines.svh"

module three_marker_pose_estimator import tmpe_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [COORD_W-1:0]          s_led0_x,
    input  logic [COORD_W-1:0]          s_led0_y,
    input  logic [COORD_W-1:0]          s_led1_x,
    input  logic [COORD_W-1:0]          s_led1_y,
    input  logic [COORD_W-1:0]          s_led2_x,
    input  logic [COORD_W-1:0]          s_led2_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [CENTER_W-1:0]         m_center_x,
    output logic [CENTER_W-1:0]         m_center_y,
    output logic signed [HEADING_W-1:0] m_heading,
    output logic [FRONT_W-1:0]          m_front_index
);

    localparam int Z_W = ANGLE_FRAC_BITS + ANGLE_INT_BITS;
    localparam logic signed [Z_W-1:0] PI_Q = Z_W'(q30_to_angle(PI_Q30, ANGLE_FRAC_BITS));

    logic                   v_chain [CORDIC_STAGES+1];
    logic                   r_chain [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] x_chain [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_chain [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  z_chain [CORDIC_STAGES+1];
    side_t                  s_chain [CORDIC_STAGES+1];

    logic                   last_valid;
    side_t                  last_side;
    logic signed [Z_W-1:0]  z_clamp;
    logic                   out_en;

    logic                        m_valid_reg;
    logic [CENTER_W-1:0]         m_center_x_reg;
    logic [CENTER_W-1:0]         m_center_y_reg;
    logic signed [HEADING_W-1:0] m_heading_reg;
    logic signed [HEADING_W-1:0] m_heading_next;
    logic [FRONT_W-1:0]          m_front_reg;

    tmpe_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .Z_W             (Z_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .led0_x    (s_led0_x),
        .led0_y    (s_led0_y),
        .led1_x    (s_led1_x),
        .led1_y    (s_led1_y),
        .led2_x    (s_led2_x),
        .led2_y    (s_led2_y),
        .out_valid (v_chain[0]),
        .out_ready (r_chain[0]),
        .x_out     (x_chain[0]),
        .y_out     (y_chain[0]),
        .z_out     (z_chain[0]),
        .side_out  (s_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        tmpe_cordic_cell #(
            .STAGE           (i),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
            .Z_W             (Z_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v_chain[i]),
            .in_ready  (r_chain[i]),
            .x_in      (x_chain[i]),
            .y_in      (y_chain[i]),
            .z_in      (z_chain[i]),
            .side_in   (s_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_ready (r_chain[i+1]),
            .x_out     (x_chain[i+1]),
            .y_out     (y_chain[i+1]),
            .z_out     (z_chain[i+1]),
            .side_out  (s_chain[i+1])
        );
    end

    assign last_valid              = v_chain[CORDIC_STAGES];
    assign last_side               = s_chain[CORDIC_STAGES];
    assign out_en                  = !m_valid_reg || m_ready;
    assign r_chain[CORDIC_STAGES]  = out_en;

    always_comb begin
        if (z_chain[CORDIC_STAGES] > PI_Q) begin
            z_clamp = PI_Q;
        end else if (z_chain[CORDIC_STAGES] < -PI_Q) begin
            z_clamp = -PI_Q;
        end else begin
            z_clamp = z_chain[CORDIC_STAGES];
        end
        if (last_side.zero) begin
            m_heading_next = '0;
        end else begin
            m_heading_next = HEADING_W'(z_clamp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && last_valid) begin
            m_center_x_reg <= last_side.center_x;
            m_center_y_reg <= last_side.center_y;
            m_heading_reg  <= m_heading_next;
            m_front_reg    <= last_side.front;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_center_x    = m_center_x_reg;
    assign m_center_y    = m_center_y_reg;
    assign m_heading     = m_heading_reg;
    assign m_front_index = m_front_reg;

    `TMPE_ASSERT_NXT(a_out_idle, aclk, aresetn, out_en && !last_valid, !m_valid)
    `TMPE_ASSERT_NXT(a_zero_heading, aclk, aresetn, out_en && last_valid && last_side.zero, m_heading == '0)
    `TMPE_ASSERT_IMP(a_front_range, aclk, aresetn, m_valid, m_front_index == FRONT_LED0 || m_front_index == FRONT_LED1 || m_front_index == FRONT_LED2)

endmodule

>>> tb/three_marker_pose_estimator_tb.sv
module three_marker_pose_estimator_tb import tmpe_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int ANGLE_FRAC   = ANGLE_FRAC_BITS_DEF;
    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int GUARD_SHIFT  = 8;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int MAX_WAIT     = 19;
    localparam int HOLD_OFF     = 300;
    localparam int BURST_ITEMS  = 60;
    localparam int RANDOM_ITEMS = 580;
    localparam int SETTLE       = 40;
    localparam int IDLE_LIMIT   = 2000;

    localparam longint ARCTAN_Q30 [24] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint FULL_PI_Q30 = 64'sd3373259426;

    typedef struct packed {
        coord_t led0_x;
        coord_t led0_y;
        coord_t led1_x;
        coord_t led1_y;
        coord_t led2_x;
        coord_t led2_y;
    } triple_t;

    typedef struct packed {
        logic [CENTER_W-1:0]         center_x;
        logic [CENTER_W-1:0]         center_y;
        logic signed [HEADING_W-1:0] heading;
        logic [FRONT_W-1:0]          front;
    } pose_t;

    typedef struct {
        triple_t leds;
        bit      known;
        pose_t   want;
    } plan_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    coord_t                      s_led0_x = '0;
    coord_t                      s_led0_y = '0;
    coord_t                      s_led1_x = '0;
    coord_t                      s_led1_y = '0;
    coord_t                      s_led2_x = '0;
    coord_t                      s_led2_y = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [CENTER_W-1:0]         m_center_x;
    logic [CENTER_W-1:0]         m_center_y;
    logic signed [HEADING_W-1:0] m_heading;
    logic [FRONT_W-1:0]          m_front_index;

    pose_t     poses_due [$];
    plan_row_t plan [$];
    pose_t     due;
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        hold_off_req = 1'b0;
    bit        source_burst = 1'b0;
    bit        source_calm = 1'b0;
    bit        sink_calm = 1'b0;

    three_marker_pose_estimator #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC),
        .CORDIC_STAGES  (STAGES)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_led0_x     (s_led0_x),
        .s_led0_y     (s_led0_y),
        .s_led1_x     (s_led1_x),
        .s_led1_y     (s_led1_y),
        .s_led2_x     (s_led2_x),
        .s_led2_y     (s_led2_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y),
        .m_heading    (m_heading),
        .m_front_index(m_front_index)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic longint angle_code(input longint q30);
        return ((q30 >>> (29 - ANGLE_FRAC)) + 1) >>> 1;
    endfunction

    function automatic logic signed [HEADING_W-1:0] bearing(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys, pi_code;
        int     i;
        if (dx == 0 && dy == 0)
            return '0;
        x = dx <<< GUARD_SHIFT;
        y = dy <<< GUARD_SHIFT;
        z = 0;
        pi_code = angle_code(FULL_PI_Q30);
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = angle_code(HALF_PI_Q30);
            end else begin
                x = -y;
                y = t;
                z = -angle_code(HALF_PI_Q30);
            end
        end
        for (i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + angle_code(ARCTAN_Q30[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - angle_code(ARCTAN_Q30[i]);
            end
        end
        if (z > pi_code)
            z = pi_code;
        if (z < -pi_code)
            z = -pi_code;
        return HEADING_W'(z);
    endfunction

    function automatic pose_t estimate_pose(input triple_t t);
        longint             px [3];
        longint             py [3];
        longint             d01, d12, d20;
        logic [FRONT_W-1:0] front;
        int                 f, ia, ib;
        pose_t              p;
        px[0] = t.led0_x;
        py[0] = t.led0_y;
        px[1] = t.led1_x;
        py[1] = t.led1_y;
        px[2] = t.led2_x;
        py[2] = t.led2_y;
        d01 = (px[0] - px[1]) * (px[0] - px[1]) + (py[0] - py[1]) * (py[0] - py[1]);
        d12 = (px[1] - px[2]) * (px[1] - px[2]) + (py[1] - py[2]) * (py[1] - py[2]);
        d20 = (px[2] - px[0]) * (px[2] - px[0]) + (py[2] - py[0]) * (py[2] - py[0]);
        if (d01 < d12 && d01 < d20)
            front = FRONT_LED2;
        else if (d12 < d20 && d12 < d01)
            front = FRONT_LED0;
        else
            front = FRONT_LED1;
        f  = int'(front);
        ia = (f + 1) % 3;
        ib = (f + 2) % 3;
        p.center_x = CENTER_W'(2 * px[f] + px[ia] + px[ib]);
        p.center_y = CENTER_W'(2 * py[f] + py[ia] + py[ib]);
        p.heading  = bearing(2 * px[f] - px[ia] - px[ib], 2 * py[f] - py[ia] - py[ib]);
        p.front    = front;
        return p;
    endfunction

    function automatic coord_t clip_coord(input int v);
        return coord_t'(v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v));
    endfunction

    function automatic triple_t draw_triple();
        int      px [3];
        int      py [3];
        int      mode, cx, cy, u, v, reach, slot, k;
        triple_t t;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1: begin
                for (k = 0; k < 3; k++) begin
                    px[k] = $urandom_range(0, COORD_MAX);
                    py[k] = $urandom_range(0, COORD_MAX);
                end
            end
            7: begin
                // apex equidistant from the other two: a tie
                slot = $urandom_range(0, 2);
                cx = $urandom_range(300, COORD_MAX - 300);
                cy = $urandom_range(300, COORD_MAX - 300);
                u = int'($urandom_range(0, 600)) - 300;
                v = int'($urandom_range(0, 600)) - 300;
                px[slot] = cx;
                py[slot] = cy;
                px[(slot + 1) % 3] = cx + u;
                py[(slot + 1) % 3] = cy + v;
                px[(slot + 2) % 3] = cx - u;
                py[(slot + 2) % 3] = cy - v;
            end
            8: begin
                for (k = 0; k < 3; k++) begin
                    px[k] = $urandom_range(0, 3);
                    py[k] = $urandom_range(0, 3);
                end
            end
            9: begin
                for (k = 0; k < 3; k++) begin
                    px[k] = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                 : $urandom_range(COORD_MAX - 15, COORD_MAX);
                    py[k] = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                 : $urandom_range(COORD_MAX - 15, COORD_MAX);
                end
            end
            default: begin
                // close back pair, front further out, front slot random
                cx = $urandom_range(0, COORD_MAX);
                cy = $urandom_range(0, COORD_MAX);
                u = int'($urandom_range(0, 80)) - 40;
                v = int'($urandom_range(0, 80)) - 40;
                reach = $urandom_range(100, 4000);
                slot = $urandom_range(0, 2);
                px[slot] = cx + int'($urandom_range(0, 2 * reach)) - reach;
                py[slot] = cy + int'($urandom_range(0, 2 * reach)) - reach;
                px[(slot + 1) % 3] = cx + u;
                py[(slot + 1) % 3] = cy + v;
                px[(slot + 2) % 3] = cx - u + int'($urandom_range(0, 4)) - 2;
                py[(slot + 2) % 3] = cy - v + int'($urandom_range(0, 4)) - 2;
            end
        endcase
        t.led0_x = clip_coord(px[0]);
        t.led0_y = clip_coord(py[0]);
        t.led1_x = clip_coord(px[1]);
        t.led1_y = clip_coord(py[1]);
        t.led2_x = clip_coord(px[2]);
        t.led2_y = clip_coord(py[2]);
        return t;
    endfunction

    task automatic plan_row(input int l0x, input int l0y, input int l1x, input int l1y,
                            input int l2x, input int l2y, input bit known = 1'b0,
                            input int cx = 0, input int cy = 0, input int hd = 0,
                            input logic [FRONT_W-1:0] fr = FRONT_LED1);
        plan_row_t r;
        r.leds          = '{coord_t'(l0x), coord_t'(l0y), coord_t'(l1x),
                            coord_t'(l1y), coord_t'(l2x), coord_t'(l2y)};
        r.known         = known;
        r.want.center_x = CENTER_W'(cx);
        r.want.center_y = CENTER_W'(cy);
        r.want.heading  = HEADING_W'(hd);
        r.want.front    = fr;
        plan.insert(plan.size(), r);
    endtask

    // call at a rising edge; returns at a rising edge
    task automatic offer_triple(input triple_t t, input pose_t want);
        int gap;
        s_valid  <= 1'b1;
        s_led0_x <= t.led0_x;
        s_led0_y <= t.led0_y;
        s_led1_x <= t.led1_x;
        s_led1_y <= t.led1_y;
        s_led2_x <= t.led2_x;
        s_led2_y <= t.led2_y;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        poses_due.insert(poses_due.size(), want);
        if ($urandom_range(0, 39) == 0)
            source_calm = !source_calm;
        gap = (source_burst || source_calm) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_for_drain();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (poses_due.size() != 0);
    endtask

    initial begin : stimulus
        triple_t leds;
        pose_t   want;
        int      n;
        plan_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, FRONT_LED1);
        plan_row(32767, 32767, 32767, 32767, 32767, 32767,
                 1'b1, 131068, 131068, 0, FRONT_LED1);
        plan_row(1000, 2000, 1000, 2000, 1000, 2000, 1'b1, 4000, 8000, 0, FRONT_LED1);
        plan_row(0, 0, 0, 0, 32767, 32767);
        plan_row(32767, 0, 0, 0, 0, 0);
        plan_row(0, 32767, 0, 0, 0, 0);
        plan_row(0, 0, 32767, 0, 0, 0);
        plan_row(0, 0, 0, 32767, 0, 0);
        plan_row(0, 0, 0, 0, 32767, 0);
        plan_row(0, 0, 0, 0, 0, 32767);
        plan_row(32767, 32767, 0, 0, 32767, 32767);
        plan_row(110, 100, 90, 100, 100, 100);
        plan_row(110, 100, 100, 100, 90, 100);
        plan_row(1000, 1000, 1000, 1002, 0, 1001);
        plan_row(1000, 1000, 1000, 1002, 0, 1000);
        plan_row(500, 0, 502, 0, 501, 32767);
        plan_row(500, 32767, 502, 32767, 501, 0);
        plan_row(32767, 0, 32767, 1, 0, 32767);
        plan_row(21845, 10922, 10922, 21845, 5461, 27306);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            want = plan[i].known ? plan[i].want : estimate_pose(plan[i].leds);
            offer_triple(plan[i].leds, want);
        end
        hold_for_drain();

        // stall the sink while offering back to back
        hold_off_req = 1'b1;
        source_burst = 1'b1;
        repeat (BURST_ITEMS) begin
            leds = draw_triple();
            offer_triple(leds, estimate_pose(leds));
        end
        source_burst = 1'b0;

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                hold_for_drain();
            leds = draw_triple();
            offer_triple(leds, estimate_pose(leds));
        end

        hold_for_drain();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : sink
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (poses_due.size() == 0) begin
                $display("%0t: unexpected beat: center (%0d,%0d) heading %0d front %0d",
                         $time, m_center_x, m_center_y, m_heading, m_front_index);
                mismatches++;
            end else begin
                due = poses_due.pop_front();
                if (m_center_x !== due.center_x) begin
                    $display("%0t: center_x expected %0d actual %0d",
                             $time, due.center_x, m_center_x);
                    mismatches++;
                end
                if (m_center_y !== due.center_y) begin
                    $display("%0t: center_y expected %0d actual %0d",
                             $time, due.center_y, m_center_y);
                    mismatches++;
                end
                if (m_heading !== due.heading) begin
                    $display("%0t: heading expected %0d actual %0d",
                             $time, due.heading, m_heading);
                    mismatches++;
                end
                if (m_front_index !== due.front) begin
                    $display("%0t: front_index expected %0d actual %0d",
                             $time, due.front, m_front_index);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, poses_due.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
